// ===== src/rtd_pkg.sv =====
// Shared types, widths and helpers for the integer to radix digit converter.
// No dependencies; used by rtd_div and integer_to_radix_digits_unit.
package rtd_pkg;

   localparam int VALUE_BITS  = 64;
   localparam int BITCNT_W    = $clog2(VALUE_BITS);
   localparam int DIGIT_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int MAX_CHARS   = 64;
   localparam int ADDR_W      = $clog2(MAX_CHARS);
   localparam int COUNT_W     = ADDR_W + 1;
   localparam int RADIX_W     = 6;
   localparam int PAD_W       = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [PAD_W-1:0]   PAD_MAX     = PAD_W'(MAX_CHARS);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(8'h41);

   localparam logic CSR_RADIX      = 1'b0;
   localparam logic CSR_MIN_DIGITS = 1'b1;

   typedef struct packed {
      logic done;
      logic quot_nonzero;
   } div_status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DIGIT_W'(10)) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_A + CHAR_W'(d - DIGIT_W'(10));
      end
      return c;
   endfunction

endpackage

// ===== src/rtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rtd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder is one digit.
// Depends on rtd_pkg.
module rtd_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rtd_pkg::VALUE_BITS-1:0]      dividend,
   input  logic [rtd_pkg::RADIX_W-1:0]         radix,
   output rtd_pkg::div_status_type             status,
   output logic [rtd_pkg::VALUE_BITS-1:0]      quotient,
   output logic [rtd_pkg::DIGIT_W-1:0]         digit
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic                               nz_ff, nz_in;
   logic [rtd_pkg::BITCNT_W-1:0]       bitcnt_ff, bitcnt_in;
   logic [rtd_pkg::VALUE_BITS-1:0]     num_ff, num_in;
   logic [rtd_pkg::DIGIT_W-1:0]        rem_ff, rem_in;
   logic [rtd_pkg::DIGIT_W:0]          rem_sh;
   logic                               ge;

   always_comb begin
      rem_sh    = {rem_ff, num_ff[rtd_pkg::VALUE_BITS-1]};
      ge        = rem_sh >= {1'b0, radix};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      nz_in     = nz_ff;
      bitcnt_in = bitcnt_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      if (start) begin
         busy_in   = 1'b1;
         nz_in     = 1'b0;
         bitcnt_in = rtd_pkg::BITCNT_W'(rtd_pkg::VALUE_BITS - 1);
         num_in    = dividend;
         rem_in    = '0;
      end else if (busy_ff) begin
         rem_in    = ge ? rtd_pkg::DIGIT_W'(rem_sh - {1'b0, radix})
                        : rtd_pkg::DIGIT_W'(rem_sh);
         num_in    = {num_ff[rtd_pkg::VALUE_BITS-2:0], ge};
         nz_in     = nz_ff | ge;
         bitcnt_in = bitcnt_ff - rtd_pkg::BITCNT_W'(1);
         if (bitcnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      nz_ff     <= nz_in;
      bitcnt_ff <= bitcnt_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
   end

   assign status.done         = done_ff;
   assign status.quot_nonzero = nz_ff;
   assign quotient            = num_ff;
   assign digit               = rem_ff;

endmodule

// ===== src/integer_to_radix_digits_unit.sv =====
// Top level of the integer to radix digit converter: sequencer, digit store, result beat.
// Depends on rtd_pkg, rtd_div and rtd_ram.
//
// Converts one 64-bit unsigned value per request beat into ASCII digits in base 2..36,
// most significant first, one character per response beat, left-padded with '0' to
// min_digits (capped at 64); a negative request gives one error beat. One value at a time:
// each digit comes from a run of the bit-serial divider and is written to the digit store,
// then each character is fetched from the digit store (S_FETCH, S_LOAD) and sent as one
// response beat (S_SEND), which waits while the response side stalls. The request side
// is ready only while the unit is idle.
module integer_to_radix_digits_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] value
   input  logic        req_tuser,   // [0] is_negative
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] digit_char, [7] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] error
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [6:0]  csr_wr_data
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_FETCH = 5'b00100,
      S_LOAD  = 5'b01000,
      S_SEND  = 5'b10000
   } state_type;

   state_type                            state_ff, state_in;
   logic [rtd_pkg::RADIX_W-1:0]          radix_ff, radix_in;
   logic [rtd_pkg::PAD_W-1:0]            min_ff, min_in;
   logic [rtd_pkg::RADIX_W-1:0]          base_ff, base_in;
   logic [rtd_pkg::PAD_W-1:0]            pad_ff, pad_in;
   logic [rtd_pkg::COUNT_W-1:0]          count_ff, count_in;
   logic [rtd_pkg::COUNT_W-1:0]          idx_ff, idx_in;
   logic                                 rvalid_ff, rvalid_in;
   logic [rtd_pkg::CHAR_W-1:0]           rchar_ff, rchar_in;
   logic                                 rlast_ff, rlast_in;
   logic                                 rerr_ff, rerr_in;

   logic                                 req_beat, rsp_beat;
   logic                                 div_start;
   logic [rtd_pkg::VALUE_BITS-1:0]       div_dividend;
   rtd_pkg::div_status_type              div_stat;
   logic [rtd_pkg::VALUE_BITS-1:0]       div_quot;
   logic [rtd_pkg::DIGIT_W-1:0]          div_digit;
   logic [rtd_pkg::DIGIT_W-1:0]          ram_rd;
   logic [rtd_pkg::COUNT_W-1:0]          cnt_next;
   logic [rtd_pkg::COUNT_W-1:0]          total;

   assign req_tready = state_ff == S_IDLE;
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_beat   = rsp_tvalid & rsp_tready;
   assign cnt_next   = count_ff + rtd_pkg::COUNT_W'(1);

   always_comb begin
      radix_in = radix_ff;
      min_in   = min_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rtd_pkg::CSR_RADIX:      radix_in = csr_wr_data[rtd_pkg::RADIX_W-1:0];
            rtd_pkg::CSR_MIN_DIGITS: min_in   = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      pad_in       = pad_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rvalid_in    = rvalid_ff;
      rchar_in     = rchar_ff;
      rlast_in     = rlast_ff;
      rerr_in      = rerr_ff;
      div_start    = 1'b0;
      div_dividend = div_quot;
      total        = (cnt_next > rtd_pkg::COUNT_W'(pad_ff)) ? cnt_next
                                                          : rtd_pkg::COUNT_W'(pad_ff);
      unique case (state_ff)
         S_IDLE: begin
            div_dividend = req_tdata[rtd_pkg::VALUE_BITS-1:0];
            if (req_beat) begin
               if (req_tuser) begin
                  rvalid_in = 1'b1;
                  rchar_in  = '0;
                  rlast_in  = 1'b1;
                  rerr_in   = 1'b1;
                  state_in  = S_SEND;
               end else begin
                  if (radix_ff < rtd_pkg::RADIX_MIN) begin
                     base_in = rtd_pkg::RADIX_MIN;
                  end else if (radix_ff > rtd_pkg::RADIX_MAX) begin
                     base_in = rtd_pkg::RADIX_MAX;
                  end else begin
                     base_in = radix_ff;
                  end
                  pad_in    = (min_ff > rtd_pkg::PAD_MAX) ? rtd_pkg::PAD_MAX : min_ff;
                  count_in  = '0;
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               count_in = cnt_next;
               if (div_stat.quot_nonzero &&
                   cnt_next != rtd_pkg::COUNT_W'(rtd_pkg::MAX_CHARS)) begin
                  div_start = 1'b1;
               end else begin
                  idx_in   = total - rtd_pkg::COUNT_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            rvalid_in = 1'b1;
            rchar_in  = (idx_ff < count_ff) ? rtd_pkg::digit_to_char(ram_rd)
                                            : rtd_pkg::CHAR_ZERO;
            rlast_in  = idx_ff == '0;
            rerr_in   = 1'b0;
            state_in  = S_SEND;
         end
         S_SEND: begin
            if (rsp_beat) begin
               rvalid_in = 1'b0;
               idx_in    = idx_ff - rtd_pkg::COUNT_W'(1);
               state_in  = rlast_ff ? S_IDLE : S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         radix_ff  <= rtd_pkg::RADIX_RESET;
         min_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         radix_ff  <= radix_in;
         min_ff    <= min_in;
         rvalid_ff <= rvalid_in;
      end
      base_ff  <= base_in;
      pad_ff   <= pad_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      rchar_ff <= rchar_in;
      rlast_ff <= rlast_in;
      rerr_ff  <= rerr_in;
   end

   rtd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .radix    (base_ff),
      .status   (div_stat),
      .quotient (div_quot),
      .digit    (div_digit)
   );

   rtd_ram #(
      .WIDTH (rtd_pkg::DIGIT_W),
      .DEPTH (rtd_pkg::MAX_CHARS)
   ) u_digits (
      .clock   (clock),
      .wr_en   (state_ff == S_DIV && div_stat.done),
      .wr_addr (count_ff[rtd_pkg::ADDR_W-1:0]),
      .wr_data (div_digit),
      .rd_addr (idx_ff[rtd_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd)
   );

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {1'b0, rchar_ff};
   assign rsp_tlast  = rlast_ff;
   assign rsp_tuser  = rerr_ff;

endmodule

// ===== tb/integer_to_radix_digits_unit_tb.sv =====
// Testbench for integer_to_radix_digits_unit: queue-fed request driver, checking response
// monitor, and an in-bench digit predictor, run over directed and random radix and padding.
// Depends on rtd_pkg and the integer_to_radix_digits_unit RTL.
module integer_to_radix_digits_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtd_pkg::*;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int IDLE_PCT    = 21;
   localparam int SETTLE      = 8;
   localparam int TAIL        = 100;

   typedef struct packed {
      logic [63:0] value;
      logic        neg;
   } conv_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              err;
   } digit_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;     // [63:0] value
   logic        req_tuser = 1'b0;   // [0] is_negative
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [6:0] digit_char, [7] zero
   logic        rsp_tlast;
   logic        rsp_tuser;          // [0] error
   logic        csr_wr_en = 1'b0;
   logic        csr_index = CSR_RADIX;
   logic [6:0]  csr_wr_data = '0;

   conv_item_type      pending_values[$];
   digit_beat_type     expected_chars[$];
   logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
   logic [PAD_W-1:0]   cfg_min_digits = '0;
   bit                 calm = 1'b0;
   int                 mismatches = 0;
   int unsigned        cycle_count = 0;

   integer_to_radix_digits_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned effective_radix();
      if (cfg_radix < RADIX_MIN) begin
         return RADIX_MIN;
      end else if (cfg_radix > RADIX_MAX) begin
         return RADIX_MAX;
      end
      return cfg_radix;
   endfunction

   task automatic predict_digits(input logic [63:0] value, input logic neg);
      logic [63:0]       n;
      logic [63:0]       base;
      logic [63:0]       d;
      logic [CHAR_W-1:0] rev[MAX_CHARS];
      int unsigned       pad;
      int unsigned       count;
      int unsigned       total;
      int unsigned       from_end;
      digit_beat_type    beat;
      base = 64'(effective_radix());
      pad = (cfg_min_digits > PAD_MAX) ? MAX_CHARS : cfg_min_digits;
      if (neg) begin
         beat.ch = '0;
         beat.last = 1'b1;
         beat.err = 1'b1;
         expected_chars = {expected_chars, beat};
      end else begin
         n = value & ({64{1'b1}} >> (64 - VALUE_BITS));
         count = 0;
         do begin
            d = n % base;
            rev[count] = (d < 10) ? CHAR_ZERO + CHAR_W'(d) : CHAR_A + CHAR_W'(d - 10);
            count++;
            n = n / base;
         end while (n != 0 && count < MAX_CHARS);
         total = (pad > count) ? pad : count;
         for (int unsigned k = 0; k < total; k++) begin
            from_end = total - 1 - k;
            beat.ch = (from_end < count) ? rev[from_end] : CHAR_ZERO;
            beat.last = (k + 1 == total);
            beat.err = 1'b0;
            expected_chars = {expected_chars, beat};
         end
      end
   endtask

   // Request driver: hold a beat until accepted, then load the next pending item.
   always @(posedge clock) begin : req_driver
      conv_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_digits(req_tdata, req_tuser);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_values.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               nxt = pending_values.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.value;
               req_tuser <= nxt.neg;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: stall at random, compare each beat with the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      digit_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected beat: expected none, actual data %h last %b error %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_tdata !== {1'b0, want.ch} || rsp_tlast !== want.last
                   || rsp_tuser !== want.err) begin
                  $display("%0t: mismatch: expected %h/%b/%b, actual %h/%b/%b",
                           $time, {1'b0, want.ch}, want.last, want.err,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, expected_chars.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_csr(input logic idx, input logic [6:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      if (idx == CSR_RADIX) begin
         cfg_radix = data[RADIX_W-1:0];
      end else begin
         cfg_min_digits = data;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_item(input logic [63:0] value, input logic neg);
      conv_item_type it;
      it.value = value;
      it.neg = neg;
      pending_values = {pending_values, it};
   endtask

   // Hold the sender until every expected beat has arrived, then let the unit settle.
   task automatic drain();
      while (pending_values.size() != 0 || req_tvalid || expected_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic add_random_items(input int num);
      logic [63:0] v;
      int unsigned len;
      for (int i = 0; i < num; i++) begin
         v = {$urandom, $urandom};
         if (effective_radix() < 8) begin
            len = $urandom_range(0, 14);
         end else begin
            len = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(0, 64);
         end
         if (len < 64) begin
            v = v & ((64'd1 << len) - 64'd1);
         end
         add_item(v, $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      logic [6:0] radix_w;
      logic [6:0] min_w;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: decimal, no padding.
      add_item(64'd0, 1'b0);
      add_item(64'd1, 1'b0);
      add_item(64'd9, 1'b0);
      add_item(64'd10, 1'b0);
      add_item({64{1'b1}}, 1'b0);
      add_item(64'd12345, 1'b1);
      add_item(64'd0, 1'b1);
      add_item(64'd12345, 1'b0);
      drain();

      // Radix zero, with the unused top bit set, acts as binary.
      write_csr(CSR_RADIX, 7'h40);
      add_item(64'd0, 1'b0);
      add_item({64{1'b1}}, 1'b0);
      add_item(64'd5, 1'b0);
      add_item(64'h8000_0000_0000_0000, 1'b0);
      drain();

      // Radix one acts as binary; padding above the cap is clamped.
      write_csr(CSR_RADIX, 7'd1);
      write_csr(CSR_MIN_DIGITS, 7'd70);
      add_item(64'd0, 1'b0);
      add_item(64'd3, 1'b0);
      add_item(64'd3, 1'b1);
      drain();

      write_csr(CSR_RADIX, 7'd36);
      write_csr(CSR_MIN_DIGITS, 7'h7F);
      add_item({64{1'b1}}, 1'b0);
      add_item(64'd35, 1'b0);
      add_item(64'd36, 1'b0);
      drain();

      // Radix above the cap acts as base 36.
      write_csr(CSR_RADIX, 7'd63);
      write_csr(CSR_MIN_DIGITS, 7'd5);
      add_item(64'd35, 1'b0);
      add_item(64'd36, 1'b0);
      add_item({64{1'b1}}, 1'b0);
      add_item(64'd0, 1'b0);
      drain();

      write_csr(CSR_RADIX, 7'd16);
      write_csr(CSR_MIN_DIGITS, 7'd64);
      add_item(64'hDEAD_BEEF_0123_4567, 1'b0);
      add_item(64'h5555_AAAA_5555_AAAA, 1'b1);
      add_item(64'd0, 1'b0);
      drain();

      for (int phase = 0; phase < 7; phase++) begin
         if ($urandom_range(0, 3) == 0) begin
            radix_w = 7'($urandom_range(0, 127));
         end else begin
            radix_w = {1'($urandom_range(0, 1)), 6'($urandom_range(8, 36))};
         end
         if ($urandom_range(0, 9) < 7) begin
            min_w = 7'($urandom_range(0, 24));
         end else begin
            min_w = 7'($urandom_range(0, 127));
         end
         write_csr(CSR_RADIX, radix_w);
         write_csr(CSR_MIN_DIGITS, min_w);
         calm = (phase == 3);
         add_random_items(26);
         drain();
      end
      calm = 1'b0;

      repeat (TAIL) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rtd_pkg.sv
src/rtd_ram.sv
src/rtd_div.sv
src/integer_to_radix_digits_unit.sv
tb/integer_to_radix_digits_unit_tb.sv
